// ===== src/rdbem_pkg.sv =====
// shared constants, types and command structs for the region-decoded memory
`timescale 1ns / 1ps
package rdbem_pkg;

  // region geometry: byte offset bits, four byte lanes per row
  localparam int REGION_ADDR_BITS = 20;
  localparam int LANES            = 4;
  localparam int LANE_BITS        = 2;
  localparam int ROW_BITS         = REGION_ADDR_BITS - LANE_BITS;
  localparam int ROWS             = 1 << ROW_BITS;

  // region select field in the top address bits
  localparam int SELECT_SHIFT = 20;
  localparam int SEL_WIDTH    = 32 - SELECT_SHIFT;
  localparam logic [SEL_WIDTH-1:0] SEL_PROGRAM = 12'h004;
  localparam logic [SEL_WIDTH-1:0] SEL_DATA    = 12'h100;
  localparam logic [SEL_WIDTH-1:0] SEL_STACK   = 12'h7FF;

  // opcode codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // stream payload layout
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;
  localparam int ADDR_LSB   = 0;
  localparam int WDATA_LSB  = 32;
  localparam int SIZE_LSB   = 64;

  // status codes
  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_BAD_REGION = 1'b1;

  typedef logic [ROW_BITS-1:0] row_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic access_en;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
  } stat_t;

endpackage

// ===== src/region_decoded_big_endian_memory.sv =====
// top level of the region-decoded big-endian byte memory
// Three 1 MiB byte regions (program at select 0x004, data 0x100, stack 0x7FF in
// address bits 31..20), each built from four byte-interleaved banks so that an
// unaligned half-word or word touches no bank twice. After reset a clearing
// pass zeroes one row of all banks per cycle, 2^18 rows in all, during which
// no request is taken. Each request then passes through capture, bank access
// (the registered read of the banks) and result load; the result register lets
// the next request enter while a result still waits downstream. A bad region
// returns status 1 and read_data 0; writes return 0; offsets wrap inside the region.
`timescale 1ns / 1ps
module region_decoded_big_endian_memory (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // address [31:0], write_data [63:32], access_size [65:64], zero [71:66]
  input  logic [rdbem_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode [0]
  input  logic [rdbem_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_data [31:0]
  output logic [rdbem_pkg::OUT_DATA_W-1:0] out_tdata,
  // status [0]
  output logic [rdbem_pkg::OUT_USER_W-1:0] out_tuser
);

  rdbem_pkg::cmd_t  cmd;
  rdbem_pkg::stat_t stat;

  // sequencing
  rdbem_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // storage and byte steering
  rdbem_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== src/rdbem_store.sv =====
// one region store: four byte-wide banks interleaved by the low offset bits
`timescale 1ns / 1ps
module rdbem_store (
  input  logic                                            clk,
  input  logic                                            clear_en,
  input  rdbem_pkg::row_t                                 clear_row,
  input  logic [rdbem_pkg::LANES-1:0]                     wr_en,
  input  logic                                            rd_en,
  input  logic [rdbem_pkg::LANES-1:0][rdbem_pkg::ROW_BITS-1:0] row,
  input  logic [rdbem_pkg::LANES-1:0][7:0]                wdata,
  output logic [rdbem_pkg::LANES-1:0][7:0]                rdata
);

  for (genvar b = 0; b < rdbem_pkg::LANES; b++) begin : g_bank
    logic [7:0] mem [rdbem_pkg::ROWS];

    // write port, the clearing pass has priority
    always_ff @(posedge clk) begin
      if (clear_en) begin
        mem[clear_row] <= 8'h00;
      end else if (wr_en[b]) begin
        mem[row[b]] <= wdata[b];
      end
    end

    // registered read port
    always_ff @(posedge clk) begin
      if (rd_en) begin
        rdata[b] <= mem[row[b]];
      end
    end
  end

endmodule

// ===== src/rdbem_datapath.sv =====
// request registers, lane mapping, region stores, clear counter and result register
`timescale 1ns / 1ps
module rdbem_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rdbem_pkg::cmd_t                     cmd,
  output rdbem_pkg::stat_t                    stat,
  input  logic [rdbem_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [rdbem_pkg::IN_USER_W-1:0]     in_tuser,
  output logic [rdbem_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [rdbem_pkg::OUT_USER_W-1:0]    out_tuser
);

  logic            req_write_r;
  logic [31:0]     req_addr_r;
  logic [31:0]     req_wdata_r;
  logic [1:0]      req_size_r;
  rdbem_pkg::row_t clr_row_r;
  rdbem_pkg::row_t clr_row_nxt;
  logic [31:0]     out_data_r;
  logic            out_status_r;

  logic [rdbem_pkg::SEL_WIDTH-1:0] sel;
  logic hit_prog, hit_data, hit_stack, hit_any;
  logic [rdbem_pkg::LANE_BITS-1:0] lane0;
  rdbem_pkg::row_t row0;
  logic [2:0] nbytes;

  logic [rdbem_pkg::LANES-1:0][1:0]                   lane_k;
  logic [rdbem_pkg::LANES-1:0][1:0]                   lane_idx;
  logic [rdbem_pkg::LANES-1:0]                        lane_used;
  logic [rdbem_pkg::LANES-1:0][rdbem_pkg::ROW_BITS-1:0] bank_row;
  logic [rdbem_pkg::LANES-1:0][7:0]                   bank_wdata;
  logic [rdbem_pkg::LANES-1:0]                        bank_wr;
  logic                                               bank_rd;
  logic [rdbem_pkg::LANES-1:0][7:0] prog_rd, data_rd, stack_rd, rd_bytes;
  logic [31:0] rd_word;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_write_r <= in_tuser[0];
      req_addr_r  <= in_tdata[rdbem_pkg::ADDR_LSB +: 32];
      req_wdata_r <= in_tdata[rdbem_pkg::WDATA_LSB +: 32];
      req_size_r  <= in_tdata[rdbem_pkg::SIZE_LSB +: 2];
    end
  end

  // clearing pass row counter
  always_comb begin
    clr_row_nxt = clr_row_r;
    if (cmd.clear_en) begin
      clr_row_nxt = clr_row_r + rdbem_pkg::row_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r <= '0;
    end else begin
      clr_row_r <= clr_row_nxt;
    end
  end

  assign stat.clear_done = (clr_row_r == '1);

  // region decode and access size
  assign sel       = req_addr_r[31:rdbem_pkg::SELECT_SHIFT];
  assign hit_prog  = (sel == rdbem_pkg::SEL_PROGRAM);
  assign hit_data  = (sel == rdbem_pkg::SEL_DATA);
  assign hit_stack = (sel == rdbem_pkg::SEL_STACK);
  assign hit_any   = hit_prog | hit_data | hit_stack;
  assign lane0     = req_addr_r[rdbem_pkg::LANE_BITS-1:0];
  assign row0      = req_addr_r[rdbem_pkg::REGION_ADDR_BITS-1:rdbem_pkg::LANE_BITS];

  always_comb begin
    unique case (req_size_r)
      rdbem_pkg::SIZE_BYTE: nbytes = 3'd1;
      rdbem_pkg::SIZE_HALF: nbytes = 3'd2;
      rdbem_pkg::SIZE_WORD: nbytes = 3'd4;
      default:              nbytes = 3'd0;
    endcase
  end

  // per-bank byte position, row (wraps at region end) and write byte
  always_comb begin
    for (int b = 0; b < rdbem_pkg::LANES; b++) begin
      lane_k[b]     = 2'(b) - lane0;
      bank_row[b]   = row0 + rdbem_pkg::row_t'(2'(b) < lane0);
      lane_used[b]  = ({1'b0, lane_k[b]} < nbytes);
      lane_idx[b]   = 2'(nbytes - 3'd1 - {1'b0, lane_k[b]});
      bank_wdata[b] = req_wdata_r[{lane_idx[b], 3'b000} +: 8];
      bank_wr[b]    = cmd.access_en & (req_write_r == rdbem_pkg::OP_WRITE) & lane_used[b];
    end
  end

  assign bank_rd = cmd.access_en & (req_write_r == rdbem_pkg::OP_READ);

  // region stores
  rdbem_store u_prog (
    .clk       (clk),
    .clear_en  (cmd.clear_en),
    .clear_row (clr_row_r),
    .wr_en     (bank_wr & {rdbem_pkg::LANES{hit_prog}}),
    .rd_en     (bank_rd),
    .row       (bank_row),
    .wdata     (bank_wdata),
    .rdata     (prog_rd)
  );

  rdbem_store u_data (
    .clk       (clk),
    .clear_en  (cmd.clear_en),
    .clear_row (clr_row_r),
    .wr_en     (bank_wr & {rdbem_pkg::LANES{hit_data}}),
    .rd_en     (bank_rd),
    .row       (bank_row),
    .wdata     (bank_wdata),
    .rdata     (data_rd)
  );

  rdbem_store u_stack (
    .clk       (clk),
    .clear_en  (cmd.clear_en),
    .clear_row (clr_row_r),
    .wr_en     (bank_wr & {rdbem_pkg::LANES{hit_stack}}),
    .rd_en     (bank_rd),
    .row       (bank_row),
    .wdata     (bank_wdata),
    .rdata     (stack_rd)
  );

  // pick the region and place the bytes big-endian
  always_comb begin
    rd_word = '0;
    for (int b = 0; b < rdbem_pkg::LANES; b++) begin
      rd_bytes[b] = hit_prog ? prog_rd[b] : (hit_data ? data_rd[b] : stack_rd[b]);
      if (lane_used[b]) begin
        rd_word = rd_word | (32'(rd_bytes[b]) << {lane_idx[b], 3'b000});
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r   <= (hit_any && (req_write_r == rdbem_pkg::OP_READ)) ? rd_word : 32'h0;
      out_status_r <= hit_any ? rdbem_pkg::STATUS_OK : rdbem_pkg::STATUS_BAD_REGION;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_status_r;

endmodule

// ===== src/rdbem_ctrl.sv =====
// controller state machine: clearing pass, request sequencing and result handshake
`timescale 1ns / 1ps
module rdbem_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output rdbem_pkg::cmd_t  cmd,
  input  rdbem_pkg::stat_t stat
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.access_en = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== bench/tb_region_decoded_big_endian_memory.sv =====
// self-checking testbench for the region-decoded big-endian byte memory
`timescale 1ns / 1ps
module tb_region_decoded_big_endian_memory;

  // bench timing
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 470;

  // reserved access size, moves no bytes
  localparam logic [1:0] SIZE_RSVD = 2'd3;

  // byte offset inside one region
  typedef logic [rdbem_pkg::REGION_ADDR_BITS-1:0] offset_t;

  // region bases and top offset
  localparam offset_t OFFSET_TOP = '1;
  localparam logic [31:0] PROG_BASE  = {rdbem_pkg::SEL_PROGRAM, 20'h00000};
  localparam logic [31:0] DATA_BASE  = {rdbem_pkg::SEL_DATA, 20'h00000};
  localparam logic [31:0] STACK_BASE = {rdbem_pkg::SEL_STACK, 20'h00000};

  // region index used to key the byte model
  typedef enum int {
    REGION_PROGRAM = 0,
    REGION_DATA    = 1,
    REGION_STACK   = 2,
    REGION_NONE    = 3
  } region_t;

  typedef struct {
    logic [31:0] read_data;
    logic        status;
  } mem_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [rdbem_pkg::IN_DATA_W-1:0] in_tdata;
  logic [rdbem_pkg::IN_USER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [rdbem_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [rdbem_pkg::OUT_USER_W-1:0] out_tuser;

  // modeled contents, keyed by region and byte offset; absent bytes are zero
  logic [7:0] mem_bytes[int];
  mem_result_t pending_results[$];
  int error_count = 0;

  // flow control knobs
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_arm = 1'b0;
  int hold_left = 0;

  region_decoded_big_endian_memory uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
  end

  always begin
    #CLK_HALF clk = ~clk;
  end

  // watchdog: covers the clearing pass plus the slowest traffic with margin
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic region_t decode_region(input logic [31:0] addr);
    logic [rdbem_pkg::SEL_WIDTH-1:0] sel;
    sel = addr[31:rdbem_pkg::SELECT_SHIFT];
    if (sel == rdbem_pkg::SEL_PROGRAM) return REGION_PROGRAM;
    if (sel == rdbem_pkg::SEL_DATA) return REGION_DATA;
    if (sel == rdbem_pkg::SEL_STACK) return REGION_STACK;
    return REGION_NONE;
  endfunction

  function automatic int byte_key(input region_t region, input offset_t off);
    return (int'(region) << rdbem_pkg::REGION_ADDR_BITS) | int'(off);
  endfunction

  // expected response of one memory request; applies writes to the byte model
  function automatic mem_result_t access_memory(input logic op, input logic [31:0] addr,
                                                input logic [31:0] wdata, input logic [1:0] size);
    mem_result_t res;
    region_t region;
    offset_t base;
    offset_t off;
    int nbytes;
    int key;
    res.read_data = '0;
    res.status = rdbem_pkg::STATUS_OK;
    region = decode_region(addr);
    base = addr[rdbem_pkg::REGION_ADDR_BITS-1:0];
    case (size)
      rdbem_pkg::SIZE_BYTE: nbytes = 1;
      rdbem_pkg::SIZE_HALF: nbytes = 2;
      rdbem_pkg::SIZE_WORD: nbytes = 4;
      default:              nbytes = 0;
    endcase
    if (region == REGION_NONE) begin
      res.status = rdbem_pkg::STATUS_BAD_REGION;
      return res;
    end
    for (int i = 0; i < nbytes; i++) begin
      if (op == rdbem_pkg::OP_WRITE) begin
        // low byte of the value lands at the highest offset
        off = base + offset_t'(nbytes - 1 - i);
        mem_bytes[byte_key(region, off)] = wdata[8*i +: 8];
      end else begin
        off = base + offset_t'(i);
        key = byte_key(region, off);
        res.read_data = {res.read_data[23:0], mem_bytes.exists(key) ? mem_bytes[key] : 8'h00};
      end
    end
    return res;
  endfunction

  // predict on accepted requests, check each accepted response against the oldest
  always @(posedge clk) begin
    mem_result_t want;
    if (rst_n && in_tvalid && in_tready) begin
      pending_results.push_back(access_memory(in_tuser[0],
                                              in_tdata[rdbem_pkg::ADDR_LSB +: 32],
                                              in_tdata[rdbem_pkg::WDATA_LSB +: 32],
                                              in_tdata[rdbem_pkg::SIZE_LSB +: 2]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request pending: read_data %h status %0d",
               out_tdata, out_tuser[0]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.read_data) begin
          $error("read_data mismatch: expected %h, actual %h", want.read_data, out_tdata);
          error_count++;
        end
        if (out_tuser[0] !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_tuser[0]);
          error_count++;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // receiver ready with random stalls
  always @(posedge clk) begin
    out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  // offer one request, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_request(input logic op, input logic [31:0] addr,
                              input logic [31:0] wdata, input logic [1:0] size);
    logic [rdbem_pkg::IN_DATA_W-1:0] payload;
    payload = '0;
    payload[rdbem_pkg::ADDR_LSB +: 32] = addr;
    payload[rdbem_pkg::WDATA_LSB +: 32] = wdata;
    payload[rdbem_pkg::SIZE_LSB +: 2] = size;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= payload;
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // random request aimed at a few hot windows so reads return written bytes
  task automatic send_random_request();
    logic [rdbem_pkg::SEL_WIDTH-1:0] sel;
    logic [19:0] off;
    logic [1:0] size;
    logic [31:0] rnd;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) sel = rdbem_pkg::SEL_PROGRAM;
    else if (pick < 60) sel = rdbem_pkg::SEL_DATA;
    else if (pick < 92) sel = rdbem_pkg::SEL_STACK;
    else begin
      rnd = $urandom;
      sel = rnd[rdbem_pkg::SEL_WIDTH-1:0];
      while (sel == rdbem_pkg::SEL_PROGRAM || sel == rdbem_pkg::SEL_DATA ||
             sel == rdbem_pkg::SEL_STACK) begin
        rnd = $urandom;
        sel = rnd[rdbem_pkg::SEL_WIDTH-1:0];
      end
    end
    pick = $urandom_range(99);
    rnd = $urandom;
    if (pick < 35) off = 20'h00000 + 20'($urandom_range(0, 15));
    else if (pick < 60) off = 20'h5A5A0 + 20'($urandom_range(0, 15));
    else if (pick < 90) off = 20'hFFFF0 + 20'($urandom_range(0, 15));
    else off = rnd[19:0];
    pick = $urandom_range(9);
    if (pick < 3) size = rdbem_pkg::SIZE_BYTE;
    else if (pick < 6) size = rdbem_pkg::SIZE_HALF;
    else if (pick < 9) size = rdbem_pkg::SIZE_WORD;
    else size = SIZE_RSVD;
    send_request($urandom_range(1) ? rdbem_pkg::OP_WRITE : rdbem_pkg::OP_READ,
                 {sel, off}, $urandom, size);
  endtask

  // extremes, every size, wrap at the region end, bad region and reserved size
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_request(rdbem_pkg::OP_READ,  PROG_BASE, 32'h0, rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_WRITE, PROG_BASE, 32'h11223344, rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE, 32'h0, rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE + 32'd1, 32'h0, rdbem_pkg::SIZE_BYTE);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE + 32'd2, 32'h0, rdbem_pkg::SIZE_HALF);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE + 32'd3, 32'h0, rdbem_pkg::SIZE_HALF);
    // half-word straddling the end of the data region
    send_request(rdbem_pkg::OP_WRITE, DATA_BASE | 32'(OFFSET_TOP), 32'h0000A5C3,
                 rdbem_pkg::SIZE_HALF);
    send_request(rdbem_pkg::OP_READ,  DATA_BASE | 32'h000FFFFE, 32'h0, rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_WRITE, STACK_BASE | 32'h000FFFFE, 32'hFFFFFFFF,
                 rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_READ,  STACK_BASE | 32'(OFFSET_TOP), 32'h0,
                 rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_WRITE, STACK_BASE + 32'd2, 32'hFFFFFF5A, rdbem_pkg::SIZE_BYTE);
    send_request(rdbem_pkg::OP_READ,  STACK_BASE, 32'h0, rdbem_pkg::SIZE_WORD);
    // bad region: no write, status set
    send_request(rdbem_pkg::OP_WRITE, 32'h00000000, 32'h12345678, rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_READ,  32'hFFFFFFFF, 32'h0, rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_READ,  32'h00500000, 32'h0, rdbem_pkg::SIZE_BYTE);
    send_request(rdbem_pkg::OP_WRITE, 32'h00400000 ^ 32'h80000000, 32'hFFFFFFFF,
                 rdbem_pkg::SIZE_BYTE);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE, 32'h0, rdbem_pkg::SIZE_WORD);
    // reserved size moves nothing
    send_request(rdbem_pkg::OP_WRITE, PROG_BASE, 32'hDEADBEEF, SIZE_RSVD);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE, 32'h0, SIZE_RSVD);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE, 32'h0, rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_READ,  32'h80000000, 32'h0, SIZE_RSVD);
    send_request(rdbem_pkg::OP_WRITE, DATA_BASE | 32'(OFFSET_TOP), 32'h00000000,
                 rdbem_pkg::SIZE_BYTE);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE | 32'h000FFFFD, 32'h0, rdbem_pkg::SIZE_WORD);
    send_request(rdbem_pkg::OP_WRITE, PROG_BASE | 32'(OFFSET_TOP), 32'h0000BEEF,
                 rdbem_pkg::SIZE_HALF);
    send_request(rdbem_pkg::OP_READ,  PROG_BASE | 32'h000FFFFE, 32'h0, rdbem_pkg::SIZE_WORD);
  endtask

  // random traffic under one idling pattern
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    repeat (RANDOM_ITEMS) send_random_request();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    repeat (40) send_random_request();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(0, 0);
    test_random_traffic(51, 0);
    test_backpressure();
    test_random_traffic(0, 51);
    test_random_traffic(17, 17);

    // drain outstanding responses
    in_tvalid <= 1'b0;
    rx_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
